### hw/rtl/dpbp_pkg.sv
package dpbp_pkg;

    localparam int STRIDE    = 2;
    localparam int FRAC_BITS = 16;
    localparam int STR_BITS  = (STRIDE > 1) ? $clog2(STRIDE) : 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_FOCAL_X    = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [2:0] REG_CENTER_X   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y   = 3'd3;
    localparam logic [2:0] REG_DEPTH_GAIN = 3'd4;
    localparam logic [2:0] REG_NEAR_LIMIT = 3'd5;
    localparam logic [2:0] REG_FAR_LIMIT  = 3'd6;
    localparam logic [2:0] REG_IMG_WIDTH  = 3'd7;

    typedef struct packed {
        logic signed [31:0] depth_sample;
        logic [7:0]         blue_in;
        logic [7:0]         green_in;
        logic [7:0]         red_in;
        logic               frame_start;
    } t_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } t_out;

    // Work handed from the front end to the back end through the queue.
    typedef struct packed {
        logic signed [31:0] depth_sample;
        logic [15:0]        col;
        logic [15:0]        row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_job;

    typedef struct packed {
        logic [30:0]        focal_x;
        logic [30:0]        focal_y;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] depth_gain;
        logic signed [31:0] near_limit;
        logic signed [31:0] far_limit;
        logic [15:0]        image_width;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SCALE, ST_NUMER, ST_NUMHI, ST_DIV, ST_DONE
    } t_state;

endpackage

### hw/rtl/depth_to_point_back_projection_top.sv
// Depth-to-point back projection.
// Input channel: one pixel transaction (depth in signed Q16.16 plus BGR
// color) on i_valid/o_stall; a transaction is taken when i_valid is high
// and o_stall is low. Pixels arrive in raster order, and frame_start marks
// the first pixel of a frame and clears the column and row counters.
// Only pixels on the stride grid are projected; others are dropped in the
// front end, which accepts one pixel per cycle while the queue has room.
// Output channel: one point transaction (x, y, z, RGB) on o_valid/i_stall.
// A point is offered after its pixel passes the queue and states MUL, SCALE,
// NUMER, NUMHI, DIV and DONE; the back end takes a new projected pixel only
// when through with the last, as its bit-serial divider runs 79 steps for
// the x and y quotients side by side; a pixel out of depth range frees it
// after SCALE. A two-entry queue sits between the front and back ends.
// Configuration: i_cfg_valid/o_cfg_ready write register i_cfg_index; the
// port is always ready. Reset (i_rst_n low, synchronous) restores the
// register defaults, clears the counters, queue and output valid flag.
// While the receiver stalls, the output register holds its point and the
// back end waits, so the queue fills and then the input stalls.
module depth_to_point_back_projection_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  dpbp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output dpbp_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import dpbp_pkg::*;

    t_cfg r_cfg;
    t_job f_job, q_job;
    logic push, full, pop, q_valid;

    assign o_cfg_ready = 1'b1;

    // Register file; each write keeps only the register's own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x     <= 31'd32768000;
            r_cfg.focal_y     <= 31'd32768000;
            r_cfg.center_x    <= 32'sd20971520;
            r_cfg.center_y    <= 32'sd15728640;
            r_cfg.depth_gain  <= 32'sd65536;
            r_cfg.near_limit  <= 32'sd0;
            r_cfg.far_limit   <= 32'sd655360;
            r_cfg.image_width <= 16'd640;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FOCAL_X:    r_cfg.focal_x     <= i_cfg_data[30:0];
                REG_FOCAL_Y:    r_cfg.focal_y     <= i_cfg_data[30:0];
                REG_CENTER_X:   r_cfg.center_x    <= i_cfg_data;
                REG_CENTER_Y:   r_cfg.center_y    <= i_cfg_data;
                REG_DEPTH_GAIN: r_cfg.depth_gain  <= i_cfg_data;
                REG_NEAR_LIMIT: r_cfg.near_limit  <= i_cfg_data;
                REG_FAR_LIMIT:  r_cfg.far_limit   <= i_cfg_data;
                REG_IMG_WIDTH:  r_cfg.image_width <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dpbp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_image_width(r_cfg.image_width),
        .o_push(push), .o_job(f_job), .i_full(full)
    );

    dpbp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job), .o_full(full),
        .i_pop(pop), .o_valid(q_valid), .o_job(q_job)
    );

    dpbp_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_valid(q_valid), .i_job(q_job),
        .o_pop(pop), .o_valid, .o_data, .i_stall
    );

endmodule

### hw/rtl/dpbp_front.sv
module dpbp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dpbp_pkg::t_in i_data,
    input  logic [15:0]   i_image_width,
    output logic          o_push,
    output dpbp_pkg::t_job o_job,
    input  logic          i_full
);
    import dpbp_pkg::*;

    logic [15:0] r_col, r_row, n_col, n_row, col, row;
    // Position of the column and row within the stride grid.
    logic [STR_BITS-1:0] r_col_ph, r_row_ph, n_col_ph, n_row_ph, col_ph, row_ph;
    logic [16:0] next;
    logic        acc, used;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign col     = i_data.frame_start ? 16'd0 : r_col;
    assign row     = i_data.frame_start ? 16'd0 : r_row;
    assign col_ph  = i_data.frame_start ? '0 : r_col_ph;
    assign row_ph  = i_data.frame_start ? '0 : r_row_ph;
    assign next    = {1'b0, col} + 17'd1;

    always_comb begin
        if (next >= {1'b0, i_image_width}) begin
            n_col    = 16'd0;
            n_row    = row + 16'd1;
            n_col_ph = '0;
            // The row phase also restarts when the row counter wraps to zero.
            if (row == 16'hFFFF || row_ph == STR_BITS'(STRIDE - 1)) begin
                n_row_ph = '0;
            end else begin
                n_row_ph = row_ph + STR_BITS'(1);
            end
        end else begin
            n_col    = next[15:0];
            n_row    = row;
            n_col_ph = (col_ph == STR_BITS'(STRIDE - 1)) ? '0 : col_ph + STR_BITS'(1);
            n_row_ph = row_ph;
        end
    end

    assign used = (col_ph == '0) && (row_ph == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (acc) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

    assign o_push             = acc && used;
    assign o_job.depth_sample = i_data.depth_sample;
    assign o_job.col          = col;
    assign o_job.row          = row;
    assign o_job.red          = i_data.red_in;
    assign o_job.green        = i_data.green_in;
    assign o_job.blue         = i_data.blue_in;

endmodule

### hw/rtl/dpbp_queue.sv
module dpbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dpbp_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dpbp_pkg::t_job  o_job
);
    import dpbp_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### hw/rtl/dpbp_back.sv
module dpbp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dpbp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  dpbp_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    output dpbp_pkg::t_out  o_data,
    input  logic            i_stall
);
    import dpbp_pkg::*;

    t_state r_state, n_state;
    t_job   r_job;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_z;
    // Magnitude numerators (|d| < 2^48, |z| <= 2^31) and sign flags.
    logic [78:0] r_num_x, r_num_y;
    logic        r_neg_x, r_neg_y;
    logic [31:0] r_rem_x, r_rem_y;
    logic [78:0] r_q_x, r_q_y;
    logic [6:0]  r_cnt;
    t_out        r_out;
    logic        r_out_v;

    logic signed [63:0] prod_sh;
    logic signed [31:0] z_sat;
    logic signed [48:0] dx, dy;
    logic [48:0] mdx, mdy;
    logic [31:0] mz;
    logic [24:0] hx, hy;
    logic [56:0] ppx, ppy;
    logic [32:0] tx, ty;
    logic [31:0] sx, sy;
    logic        gx, gy;
    logic signed [31:0] fx, fy;

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign z_sat = (prod_sh > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (prod_sh < -64'sh80000000) ? 32'sh80000000 : prod_sh[31:0];
    assign dx  = $signed(49'(r_job.col) << FRAC_BITS) - 49'(i_cfg.center_x);
    assign dy  = $signed(49'(r_job.row) << FRAC_BITS) - 49'(i_cfg.center_y);
    assign mdx = dx[48] ? 49'(-dx) : 49'(dx);
    assign mdy = dy[48] ? 49'(-dy) : 49'(dy);
    assign mz  = r_z[31] ? 32'(-r_z) : 32'(r_z);

    // The numerators are built from two partial products, the low 25 bits of
    // the offset first and the upper bits in the next cycle.
    assign hx  = (r_state == ST_NUMER) ? mdx[24:0] : {1'b0, mdx[48:25]};
    assign hy  = (r_state == ST_NUMER) ? mdy[24:0] : {1'b0, mdy[48:25]};
    assign ppx = 57'(hx) * 57'(mz);
    assign ppy = 57'(hy) * 57'(mz);

    // Restoring division step, one quotient bit per cycle.
    assign tx = {r_rem_x, r_num_x[78]};
    assign ty = {r_rem_y, r_num_y[78]};
    assign gx = tx >= {2'b0, i_cfg.focal_x};
    assign gy = ty >= {2'b0, i_cfg.focal_y};
    assign sx = gx ? 32'(tx - {2'b0, i_cfg.focal_x}) : tx[31:0];
    assign sy = gy ? 32'(ty - {2'b0, i_cfg.focal_y}) : ty[31:0];

    function automatic logic signed [31:0] fin(input logic [78:0] q, input logic neg,
                                                input logic zero_den, input logic nz);
        logic [78:0] lim;
        logic [31:0] m;
        begin
            lim = neg ? 79'h80000000 : 79'h7FFFFFFF;
            if (zero_den) m = nz ? lim[31:0] : 32'd0;
            else          m = (q > lim) ? lim[31:0] : q[31:0];
            fin = neg ? 32'(-m) : 32'(m);
        end
    endfunction

    assign fx = fin(r_q_x, r_neg_x, i_cfg.focal_x == 31'd0, (mdx != '0) && (mz != '0));
    assign fy = fin(r_q_y, r_neg_y, i_cfg.focal_y == 31'd0, (mdy != '0) && (mz != '0));

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (i_valid) begin o_pop = 1'b1; n_state = ST_MUL; end
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = (z_sat < i_cfg.near_limit || z_sat > i_cfg.far_limit)
                                ? ST_IDLE : ST_NUMER;
            ST_NUMER: n_state = ST_NUMHI;
            ST_NUMHI: n_state = ST_DIV;
            ST_DIV:   if (r_cnt == 7'd78) n_state = ST_DONE;
            ST_DONE:  if (!r_out_v || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (r_state == ST_DONE && (!r_out_v || !i_stall)) r_out_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (i_valid) r_job <= i_job;
            ST_MUL:  r_prod <= 64'(r_job.depth_sample) * 64'(i_cfg.depth_gain);
            ST_SCALE: r_z <= z_sat;
            ST_NUMER: begin
                r_num_x <= 79'(ppx);
                r_num_y <= 79'(ppy);
                r_neg_x <= dx[48] != r_z[31];
                r_neg_y <= dy[48] != r_z[31];
                r_rem_x <= '0;
                r_rem_y <= '0;
                r_cnt   <= '0;
            end
            ST_NUMHI: begin
                r_num_x <= r_num_x + {ppx[53:0], 25'd0};
                r_num_y <= r_num_y + {ppy[53:0], 25'd0};
            end
            ST_DIV: begin
                r_rem_x <= sx;
                r_rem_y <= sy;
                r_num_x <= {r_num_x[77:0], 1'b0};
                r_num_y <= {r_num_y[77:0], 1'b0};
                r_q_x   <= {r_q_x[77:0], gx};
                r_q_y   <= {r_q_y[77:0], gy};
                r_cnt   <= r_cnt + 7'd1;
            end
            default: ;
        endcase
        if (r_state == ST_DONE && (!r_out_v || !i_stall)) begin
            r_out.point_x   <= fx;
            r_out.point_y   <= fy;
            r_out.point_z   <= r_z;
            r_out.red_out   <= r_job.red;
            r_out.green_out <= r_job.green;
            r_out.blue_out  <= r_job.blue;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule
